// ===== rtl/core/dhfk_pkg.sv =====
// Shared types, constants and a helper function for the DH forward kinematics core.
package dhfk_pkg;

    localparam int MaxJoints   = 8;
    localparam int CordicSteps = 16;
    localparam int AtanCount   = 30;
    localparam int CordicRuns  = (CordicSteps < AtanCount) ? CordicSteps : AtanCount;
    localparam int JcntW       = (MaxJoints > 1) ? $clog2(MaxJoints) : 1;
    localparam int StepW       = $clog2(AtanCount + 1);

    localparam logic signed [33:0] Q30One     = 34'sd1073741824;
    localparam logic signed [33:0] PiQ30      = 34'sd3373259426;
    localparam logic signed [33:0] HalfPiQ30  = 34'sd1686629713;
    localparam logic signed [33:0] CordicGain = 34'sh026DD3B6A;

    typedef struct packed {
        logic signed [15:0] joint_angle;
        logic signed [31:0] link_offset;
        logic signed [31:0] link_length;
        logic signed [15:0] link_twist;
        logic               final_joint;
    } dhfk_in_t;

    typedef struct packed {
        logic [2:0]         joint_number;
        logic [1:0]         row_number;
        logic signed [31:0] rot_col0;
        logic signed [31:0] rot_col1;
        logic signed [31:0] rot_col2;
        logic signed [31:0] position;
        logic               pos_saturated;
        logic               last_row;
    } dhfk_out_t;

    // Datapath operations chosen by the controller.
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_LOAD   = 3'd1,   // capture item, start CORDIC on theta and alpha
        OP_CORDIC = 3'd2,   // one CORDIC iteration on both angles
        OP_LOCAL  = 3'd3,   // one local transform product
        OP_MAC    = 3'd4,   // one running product term
        OP_COMMIT = 3'd5    // update running product and counter
    } dhfk_op_t;

    typedef struct packed {
        dhfk_op_t   op;
        logic [3:0] sel;    // local product index or row/column index
        logic [1:0] term;   // MAC term within a dot product
        logic [StepW-1:0] step;
    } dhfk_cmd_t;

    typedef struct packed {
        logic final_joint;
    } dhfk_stat_t;

    function automatic logic signed [33:0] atan_q30(input logic [StepW-1:0] i);
        logic signed [33:0] v;
        case (i)
            5'd0:  v = 34'sh03243F6A8;
            5'd1:  v = 34'sh01DAC6705;
            5'd2:  v = 34'sh00FADBAFC;
            5'd3:  v = 34'sh007F56EA6;
            5'd4:  v = 34'sh003FEAB76;
            5'd5:  v = 34'sh001FFD55B;
            5'd6:  v = 34'sh000FFFAAA;
            5'd7:  v = 34'sh0007FFF55;
            5'd8:  v = 34'sh0003FFFEA;
            5'd9:  v = 34'sh0001FFFFD;
            5'd10: v = 34'sh0000FFFFF;
            5'd11: v = 34'sh00007FFFF;
            5'd12: v = 34'sh00003FFFF;
            5'd13: v = 34'sh00001FFFF;
            5'd14: v = 34'sh00000FFFF;
            5'd15: v = 34'sh000007FFF;
            5'd16: v = 34'sh000003FFF;
            5'd17: v = 34'sh000001FFF;
            5'd18: v = 34'sh000000FFF;
            5'd19: v = 34'sh0000007FF;
            5'd20: v = 34'sh0000003FF;
            5'd21: v = 34'sh0000001FF;
            5'd22: v = 34'sh0000000FF;
            5'd23: v = 34'sh00000007F;
            5'd24: v = 34'sh00000003F;
            5'd25: v = 34'sh00000001F;
            5'd26: v = 34'sh00000000F;
            5'd27: v = 34'sh000000008;
            5'd28: v = 34'sh000000004;
            5'd29: v = 34'sh000000002;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/dhfk_ctrl.sv =====
// Controller state machine that sequences the DH forward kinematics datapath.
module dhfk_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic                out_free,
    input  dhfk_pkg::dhfk_stat_t stat,
    output dhfk_pkg::dhfk_cmd_t cmd,
    output logic                busy,
    output logic                emit
);
    import dhfk_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CORDIC = 6'b000010,
        S_LOCAL  = 6'b000100,
        S_MAC    = 6'b001000,
        S_EMIT   = 6'b010000,
        S_COMMIT = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [StepW-1:0] step_reg, step_next;
    logic [3:0]       sel_reg, sel_next;
    logic [1:0]       term_reg, term_next;

    // State register and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            sel_reg   <= '0;
            term_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sel_reg   <= sel_next;
            term_reg  <= term_next;
        end
    end

    // Next state and command decode. MAC covers 3 rows x 4 columns x 3 terms;
    // each row is emitted once its four dot products are done.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        sel_next   = sel_reg;
        term_next  = term_reg;
        cmd.op     = OP_NONE;
        cmd.sel    = sel_reg;
        cmd.term   = term_reg;
        cmd.step   = step_reg;
        busy       = 1'b1;
        emit       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (in_fire)
                begin
                    cmd.op     = OP_LOAD;
                    step_next  = '0;
                    state_next = S_CORDIC;
                end
            end
            S_CORDIC:
            begin
                cmd.op    = OP_CORDIC;
                step_next = step_reg + 1'b1;
                if (step_reg == StepW'(CordicRuns - 1))
                begin
                    sel_next   = '0;
                    state_next = S_LOCAL;
                end
            end
            S_LOCAL:
            begin
                cmd.op   = OP_LOCAL;
                sel_next = sel_reg + 1'b1;
                if (sel_reg == 4'd5)
                begin
                    sel_next   = '0;
                    term_next  = '0;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                cmd.op    = OP_MAC;
                term_next = term_reg + 1'b1;
                if (term_reg == 2'd2)
                begin
                    term_next = '0;
                    sel_next  = sel_reg + 1'b1;
                    if (sel_reg[1:0] == 2'd3)
                        state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (sel_reg == 4'd12)
                        state_next = S_COMMIT;
                    else
                        state_next = S_MAC;
                end
            end
            S_COMMIT:
            begin
                cmd.op     = OP_COMMIT;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    logic unused_final;
    assign unused_final = stat.final_joint;

endmodule

// ===== rtl/core/dhfk_datapath.sv =====
// Datapath: CORDIC pair, one shared multiplier, local and running transforms.
module dhfk_datapath
(
    input  logic                 clk,
    input  dhfk_pkg::dhfk_in_t   in_item,
    input  dhfk_pkg::dhfk_cmd_t  cmd,
    input  logic                 rst_n,
    input  logic                 emit,
    output dhfk_pkg::dhfk_stat_t stat,
    output dhfk_pkg::dhfk_out_t  row_out
);
    import dhfk_pkg::*;

    // CORDIC state for theta (t) and alpha (a).
    logic signed [33:0] tx_reg, ty_reg, tz_reg, ax_reg, ay_reg, az_reg;
    logic               tneg_reg, aneg_reg;
    logic signed [31:0] d_reg, a_reg;
    logic               fin_reg;
    // Local transform entries, running product, new running product and output row.
    logic signed [31:0] lr_reg [9];
    logic signed [33:0] lp1_reg, lp2_reg;
    logic signed [31:0] rot_reg [9];
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] nrot_reg [9];
    logic signed [31:0] npos_reg [3];
    logic signed [67:0] sum_reg;
    logic [JcntW-1:0]   jcnt_reg;
    logic [1:0]         row_reg;
    logic signed [31:0] rc0_reg, rc1_reg, rc2_reg, posout_reg;
    logic               sat_reg;

    logic signed [33:0] tz0, az0, tsin, tcos, asin, acos;
    logic               tn0, an0;
    logic signed [33:0] atan_v;
    logic signed [33:0] ma, mb;
    logic signed [67:0] prod, acc_in, rsum, psum;
    logic signed [33:0] lp_r;
    logic [1:0]         r_i, c_i, tm;
    logic [3:0]         nidx;
    logic signed [33:0] cl;

    function automatic logic signed [33:0] clamp1(input logic signed [67:0] v);
        if (v > 68'sd1073741824)
            return Q30One;
        else if (v < -68'sd1073741824)
            return -Q30One;
        else
            return v[33:0];
    endfunction

    function automatic logic signed [33:0] sc(input logic signed [33:0] v, input logic n);
        logic signed [33:0] w;
        w = n ? -v : v;
        return clamp1(68'(w));
    endfunction

    // Angle reduction to CORDIC reach, arctangent lookup and sign-corrected, clamped CORDIC outputs.
    always_comb
    begin
        tz0 = 34'(in_item.joint_angle) <<< 17;
        az0 = 34'(in_item.link_twist) <<< 17;
        tn0 = 1'b0;
        an0 = 1'b0;
        if (tz0 > HalfPiQ30)
        begin
            tz0 = tz0 - PiQ30;
            tn0 = 1'b1;
        end
        else if (tz0 < -HalfPiQ30)
        begin
            tz0 = tz0 + PiQ30;
            tn0 = 1'b1;
        end
        if (az0 > HalfPiQ30)
        begin
            az0 = az0 - PiQ30;
            an0 = 1'b1;
        end
        else if (az0 < -HalfPiQ30)
        begin
            az0 = az0 + PiQ30;
            an0 = 1'b1;
        end
        atan_v = atan_q30(cmd.step);
        tcos = sc(tx_reg, tneg_reg);
        tsin = sc(ty_reg, tneg_reg);
        acos = sc(ax_reg, aneg_reg);
        asin = sc(ay_reg, aneg_reg);
    end

    // Operand selection for the shared multiplier, product, accumulation and rounding.
    always_comb
    begin
        r_i = cmd.sel[3:2];
        c_i = cmd.sel[1:0];
        tm  = cmd.term;
        nidx = {r_i, 2'b00} - {2'b00, r_i} + {2'b00, c_i};
        ma  = '0;
        mb  = '0;
        lp_r = '0;
        if (cmd.op == OP_LOCAL)
        begin
            case (cmd.sel)
                4'd0:    begin ma = tsin; mb = acos; end
                4'd1:    begin ma = tcos; mb = acos; end
                4'd2:    begin ma = tsin; mb = asin; end
                4'd3:    begin ma = tcos; mb = asin; end
                4'd4:    begin ma = asin; mb = 34'(d_reg); end
                default: begin ma = acos; mb = 34'(d_reg); end
            endcase
        end
        else
        begin
            case (r_i)
                2'd0:    ma = 34'(rot_reg[{2'b00, tm}]);
                2'd1:    ma = 34'(rot_reg[4'd3 + {2'b00, tm}]);
                default: ma = 34'(rot_reg[4'd6 + {2'b00, tm}]);
            endcase
            case (tm)
                2'd0:    lp_r = 34'(a_reg);
                2'd1:    lp_r = lp1_reg;
                default: lp_r = lp2_reg;
            endcase
            if (c_i == 2'd3)
                mb = lp_r;
            else
            begin
                case (tm)
                    2'd0:    mb = 34'(lr_reg[{2'b00, c_i}]);
                    2'd1:    mb = 34'(lr_reg[4'd3 + {2'b00, c_i}]);
                    default: mb = 34'(lr_reg[4'd6 + {2'b00, c_i}]);
                endcase
            end
        end
        prod   = 68'(ma) * 68'(mb);
        acc_in = (tm == 2'd0) ? prod : sum_reg + prod;
        rsum   = (acc_in + 68'sd536870912) >>> 30;
        psum   = rsum + 68'(pos_reg[r_i]);
        cl     = clamp1(rsum);
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                tx_reg <= CordicGain; ty_reg <= '0; tz_reg <= tz0; tneg_reg <= tn0;
                ax_reg <= CordicGain; ay_reg <= '0; az_reg <= az0; aneg_reg <= an0;
                d_reg  <= in_item.link_offset;
                a_reg  <= in_item.link_length;
                fin_reg <= in_item.final_joint;
            end
            OP_CORDIC:
            begin
                if (!tz_reg[33])
                begin
                    tx_reg <= tx_reg - (ty_reg >>> cmd.step);
                    ty_reg <= ty_reg + (tx_reg >>> cmd.step);
                    tz_reg <= tz_reg - atan_v;
                end
                else
                begin
                    tx_reg <= tx_reg + (ty_reg >>> cmd.step);
                    ty_reg <= ty_reg - (tx_reg >>> cmd.step);
                    tz_reg <= tz_reg + atan_v;
                end
                if (!az_reg[33])
                begin
                    ax_reg <= ax_reg - (ay_reg >>> cmd.step);
                    ay_reg <= ay_reg + (ax_reg >>> cmd.step);
                    az_reg <= az_reg - atan_v;
                end
                else
                begin
                    ax_reg <= ax_reg + (ay_reg >>> cmd.step);
                    ay_reg <= ay_reg - (ax_reg >>> cmd.step);
                    az_reg <= az_reg + atan_v;
                end
            end
            OP_LOCAL:
            begin
                lr_reg[0] <= tcos[31:0];
                lr_reg[1] <= 32'(-tsin);
                lr_reg[2] <= '0;
                lr_reg[5] <= 32'(-asin);
                lr_reg[8] <= acos[31:0];
                case (cmd.sel)
                    4'd0:    lr_reg[3] <= rsum[31:0];
                    4'd1:    lr_reg[4] <= rsum[31:0];
                    4'd2:    lr_reg[6] <= rsum[31:0];
                    4'd3:    lr_reg[7] <= rsum[31:0];
                    4'd4:    lp1_reg   <= -rsum[33:0];
                    default: lp2_reg   <= rsum[33:0];
                endcase
            end
            OP_MAC:
            begin
                sum_reg <= acc_in;
                if (tm == 2'd2)
                begin
                    if (c_i == 2'd3)
                    begin
                        if (psum > 68'sd2147483647)
                        begin
                            npos_reg[r_i] <= 32'sh7FFFFFFF; sat_reg <= 1'b1;
                        end
                        else if (psum < -68'sd2147483648)
                        begin
                            npos_reg[r_i] <= 32'sh80000000; sat_reg <= 1'b1;
                        end
                        else
                        begin
                            npos_reg[r_i] <= psum[31:0]; sat_reg <= 1'b0;
                        end
                        if (psum > 68'sd2147483647)
                            posout_reg <= 32'sh7FFFFFFF;
                        else if (psum < -68'sd2147483648)
                            posout_reg <= 32'sh80000000;
                        else
                            posout_reg <= psum[31:0];
                        row_reg <= r_i;
                    end
                    else
                    begin
                        nrot_reg[nidx] <= cl[31:0];
                        case (c_i)
                            2'd0:    rc0_reg <= cl[31:0];
                            2'd1:    rc1_reg <= cl[31:0];
                            default: rc2_reg <= cl[31:0];
                        endcase
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Running product, reset to identity at start and after a final joint.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
                rot_reg[k] <= (k % 4 == 0) ? 32'sd1073741824 : '0;
            for (int k = 0; k < 3; k++)
                pos_reg[k] <= '0;
            jcnt_reg <= '0;
        end
        else if (cmd.op == OP_COMMIT)
        begin
            if (fin_reg)
            begin
                for (int k = 0; k < 9; k++)
                    rot_reg[k] <= (k % 4 == 0) ? 32'sd1073741824 : '0;
                for (int k = 0; k < 3; k++)
                    pos_reg[k] <= '0;
                jcnt_reg <= '0;
            end
            else
            begin
                rot_reg <= nrot_reg;
                pos_reg <= npos_reg;
                if (jcnt_reg != JcntW'(MaxJoints - 1))
                    jcnt_reg <= jcnt_reg + 1'b1;
            end
        end
    end

    // Output row assembled from the registered row results.
    always_comb
    begin
        row_out.joint_number  = 3'(jcnt_reg);
        row_out.row_number    = row_reg;
        row_out.rot_col0      = rc0_reg;
        row_out.rot_col1      = rc1_reg;
        row_out.rot_col2      = rc2_reg;
        row_out.position      = posout_reg;
        row_out.pos_saturated = sat_reg;
        row_out.last_row      = (row_reg == 2'd2);
        stat.final_joint      = fin_reg;
    end

    logic unused_sig;
    assign unused_sig = emit ^ tz_reg[0] ^ az_reg[0];

endmodule

// ===== rtl/core/dh_forward_kinematics_chain_core.sv =====
// Top level of the modified DH forward kinematics chain core.
// One joint item is taken at a time. Each item runs the CORDIC for its joint
// angle and twist (16 iterations, both angles in parallel), six products for the
// local transform and 36 multiply-accumulate operations on one shared multiplier
// for the three rows of the running transform. After an accepted item the input
// is stalled through the CORDIC, local, MAC, row emit and commit states and while
// a row waits on the output stall, so a new item is not taken before the last one
// is through. A row result is held in an output register and goes out as one
// item; three row items leave per joint. After the joint marked final the running
// product returns to identity and the joint count to zero.
module dh_forward_kinematics_chain_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  dhfk_pkg::dhfk_in_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output dhfk_pkg::dhfk_out_t  out_data
);
    import dhfk_pkg::*;

    dhfk_cmd_t  cmd;
    dhfk_stat_t stat;
    dhfk_out_t  row;
    logic       busy, emit, in_fire, out_free;
    logic       ov_reg;
    dhfk_out_t  od_reg;

    assign in_stall = busy;
    assign in_fire  = in_valid && !busy;
    assign out_free = !ov_reg || !out_stall;

    dhfk_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
        .stat(stat), .cmd(cmd), .busy(busy), .emit(emit)
    );

    dhfk_datapath u_dp
    (
        .clk(clk), .in_item(in_data), .cmd(cmd), .rst_n(rst_n), .emit(emit),
        .stat(stat), .row_out(row)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (emit)
            ov_reg <= 1'b1;
        else if (!out_stall)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            od_reg <= row;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

endmodule
